// ===== rtl/core/range_tagged_second_chance_cache_assert.svh =====
// assertion macros for the range tagged second chance cache
`ifndef RANGE_TAGGED_SECOND_CHANCE_CACHE_ASSERT_SVH
`define RANGE_TAGGED_SECOND_CHANCE_CACHE_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define RTSC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked while out of reset
`define RTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/rtsc_pkg.sv =====
// shared constants and control/status types of the range tagged second chance cache
package rtsc_pkg;

    localparam int ENTRIES    = 8;
    localparam int THREADS    = 8;
    localparam int ENTRY_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int THREAD_W   = (THREADS > 1) ? $clog2(THREADS) : 1;
    localparam int ADDR_W     = THREAD_W + ENTRY_W;
    localparam int DEPTH      = 1 << ADDR_W;

    localparam int COUNT_W    = 4;
    localparam int TID_W      = 3;
    localparam int TS_W       = 64;
    localparam int HANDLE_W   = 32;
    localparam int SLOT_W     = 3;

    localparam int IN_FIELDS_W  = TID_W + 3 * TS_W + HANDLE_W;
    localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = SLOT_W + HANDLE_W;
    localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W    = OUT_DATA_W - OUT_FIELDS_W;

    typedef struct packed {
        logic load_in;
        logic search_step;
        logic hit_take;
        logic sweep_init;
        logic sweep_step;
        logic fill;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic cmp_hit;
        logic cmp_last;
        logic sweep_free;
    } sts_t;

endpackage

// ===== rtl/core/rtsc_ctrl.sv =====
// controller state machine of the range tagged second chance cache
module rtsc_ctrl
    import rtsc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_SWEEP,
        S_OUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (sts.cmp_hit)
                begin
                    cmd.hit_take = 1'b1;
                    state_next   = S_OUT;
                end
                else if (sts.cmp_last)
                begin
                    cmd.sweep_init = 1'b1;
                    state_next     = S_SWEEP;
                end
                else
                begin
                    cmd.search_step = 1'b1;
                end
            end
            S_SWEEP:
            begin
                if (sts.sweep_free)
                begin
                    cmd.fill   = 1'b1;
                    state_next = S_OUT;
                end
                else
                begin
                    cmd.sweep_step = 1'b1;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/rtsc_datapath.sv =====
// datapath of the range tagged second chance cache: entry store, search, sweep, result
module rtsc_datapath
    import rtsc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [COUNT_W-1:0]   cfg_wdata,
    input  logic [IN_DATA_W-1:0] in_data,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    output logic                 out_hit,
    output logic [SLOT_W-1:0]    out_slot,
    output logic [HANDLE_W-1:0]  out_handle
);

    // configuration
    logic [COUNT_W-1:0]  entries_in_use_reg;
    logic [COUNT_W-1:0]  used_n;
    logic [ENTRY_W-1:0]  last_idx;

    // captured item
    logic [THREAD_W-1:0] thr_reg;
    logic [TS_W-1:0]     ts_reg;
    logic [TS_W-1:0]     fill_start_reg;
    logic [TS_W-1:0]     fill_end_reg;
    logic [HANDLE_W-1:0] fill_handle_reg;

    // entry store
    logic [TS_W-1:0]     start_mem  [DEPTH];
    logic [TS_W-1:0]     end_mem    [DEPTH];
    logic [HANDLE_W-1:0] handle_mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    ref_reg;
    logic [ENTRY_W-1:0]  ptr_reg [THREADS];

    // search pipeline
    logic [ENTRY_W-1:0]  idx_reg;
    logic                issue_reg;
    logic                cmp_valid_reg;
    logic [ENTRY_W-1:0]  cmp_idx_reg;
    logic [TS_W-1:0]     rd_start_reg;
    logic [TS_W-1:0]     rd_end_reg;
    logic [HANDLE_W-1:0] rd_handle_reg;
    logic                rd_valid_reg;

    // sweep
    logic [ENTRY_W-1:0]  sweep_ptr_reg;
    logic [ENTRY_W-1:0]  sweep_ptr_next;
    logic [ENTRY_W-1:0]  start_ptr;
    logic [ENTRY_W-1:0]  cur_ptr;

    // result
    logic                res_hit_reg;
    logic [SLOT_W-1:0]   res_slot_reg;
    logic [HANDLE_W-1:0] res_handle_reg;
    logic                out_hit_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [HANDLE_W-1:0] out_handle_reg;

    logic                read_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]   hit_addr;
    logic [ADDR_W-1:0]   sw_addr;

    always_comb
    begin
        if (entries_in_use_reg == '0)
        begin
            used_n = COUNT_W'(1);
        end
        else if (entries_in_use_reg > COUNT_W'(ENTRIES))
        begin
            used_n = COUNT_W'(ENTRIES);
        end
        else
        begin
            used_n = entries_in_use_reg;
        end
    end

    assign last_idx = ENTRY_W'(used_n - COUNT_W'(1));
    assign read_en  = cmd.search_step && issue_reg;
    assign rd_addr  = {thr_reg, idx_reg};
    assign hit_addr = {thr_reg, cmp_idx_reg};
    assign sw_addr  = {thr_reg, sweep_ptr_reg};

    // stale pointer after a lowered entry count restarts at entry zero
    assign cur_ptr   = ptr_reg[thr_reg];
    assign start_ptr = (COUNT_W'(cur_ptr) >= used_n) ? '0 : cur_ptr;
    assign sweep_ptr_next = ((COUNT_W'(sweep_ptr_reg) + COUNT_W'(1)) == used_n)
                          ? '0 : sweep_ptr_reg + ENTRY_W'(1);

    assign sts.cmp_hit    = cmp_valid_reg && rd_valid_reg
                         && (rd_start_reg <= ts_reg) && (ts_reg < rd_end_reg);
    assign sts.cmp_last   = cmp_valid_reg && (cmp_idx_reg == last_idx);
    assign sts.sweep_free = !ref_reg[sw_addr];

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            thr_reg         <= in_data[THREAD_W-1:0];
            ts_reg          <= in_data[TID_W +: TS_W];
            fill_start_reg  <= in_data[TID_W + TS_W +: TS_W];
            fill_end_reg    <= in_data[TID_W + 2 * TS_W +: TS_W];
            fill_handle_reg <= in_data[TID_W + 3 * TS_W +: HANDLE_W];
        end
    end

    // entry store with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.fill)
        begin
            start_mem[sw_addr]  <= fill_start_reg;
            end_mem[sw_addr]    <= fill_end_reg;
            handle_mem[sw_addr] <= fill_handle_reg;
        end
        if (read_en)
        begin
            rd_start_reg  <= start_mem[rd_addr];
            rd_end_reg    <= end_mem[rd_addr];
            rd_handle_reg <= handle_mem[rd_addr];
            rd_valid_reg  <= valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entries_in_use_reg <= COUNT_W'(ENTRIES);
            valid_reg          <= '0;
            ref_reg            <= '0;
            ptr_reg            <= '{default: '0};
            idx_reg            <= '0;
            issue_reg          <= 1'b0;
            cmp_valid_reg      <= 1'b0;
            cmp_idx_reg        <= '0;
            sweep_ptr_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                entries_in_use_reg <= cfg_wdata;
            end
            if (cmd.load_in)
            begin
                idx_reg       <= '0;
                issue_reg     <= 1'b1;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.search_step)
            begin
                cmp_valid_reg <= issue_reg;
                if (issue_reg)
                begin
                    cmp_idx_reg <= idx_reg;
                    if (idx_reg == last_idx)
                    begin
                        issue_reg <= 1'b0;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + ENTRY_W'(1);
                    end
                end
            end
            if (cmd.hit_take)
            begin
                ref_reg[hit_addr] <= 1'b1;
            end
            if (cmd.sweep_init)
            begin
                sweep_ptr_reg <= start_ptr;
            end
            if (cmd.sweep_step)
            begin
                ref_reg[sw_addr] <= 1'b0;
                sweep_ptr_reg    <= sweep_ptr_next;
            end
            if (cmd.fill)
            begin
                ref_reg[sw_addr]   <= 1'b1;
                valid_reg[sw_addr] <= 1'b1;
                ptr_reg[thr_reg]   <= sweep_ptr_reg;
            end
        end
    end

    // result and output registers
    always_ff @(posedge clk)
    begin
        if (cmd.hit_take)
        begin
            res_hit_reg    <= 1'b1;
            res_slot_reg   <= SLOT_W'(cmp_idx_reg);
            res_handle_reg <= rd_handle_reg;
        end
        else if (cmd.fill)
        begin
            res_hit_reg    <= 1'b0;
            res_slot_reg   <= SLOT_W'(sweep_ptr_reg);
            res_handle_reg <= fill_handle_reg;
        end
        if (cmd.out_load)
        begin
            out_hit_reg    <= res_hit_reg;
            out_slot_reg   <= res_slot_reg;
            out_handle_reg <= res_handle_reg;
        end
    end

    assign out_hit    = out_hit_reg;
    assign out_slot   = out_slot_reg;
    assign out_handle = out_handle_reg;

endmodule

// ===== rtl/core/range_tagged_second_chance_cache.sv =====
// Top level of the range tagged second chance cache. Each thread owns a partition of eight
// entries holding a [start, end) time range and a handle. An item is looked up in its
// thread's partition one entry per cycle through the registered entry store read port;
// the lowest entry containing the timestamp is the hit. On a miss the thread's clock
// pointer sweeps the reference bits one entry per cycle and the first clear entry takes
// the fill range and handle. One item is in work at a time: a hit ends the search at once,
// while a miss searches every entry in use and then sweeps. A finished result waits in the
// output register while the next item is accepted. The whole store reads as empty after reset.
module range_tagged_second_chance_cache
    import rtsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [COUNT_W-1:0]    cfg_wdata,   // entries_in_use
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,     // thread_id, timestamp, fill_start, fill_end, fill_handle
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,     // slot, handle
    output logic [0:0]            m_tuser      // hit
);

    cmd_t                cmd;
    sts_t                sts;
    logic                out_hit;
    logic [SLOT_W-1:0]   out_slot;
    logic [HANDLE_W-1:0] out_handle;

    rtsc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    rtsc_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_data    (s_tdata),
        .cmd        (cmd),
        .sts        (sts),
        .out_hit    (out_hit),
        .out_slot   (out_slot),
        .out_handle (out_handle)
    );

    assign m_tdata = {{OUT_PAD_W{1'b0}}, out_handle, out_slot};
    assign m_tuser = out_hit;

endmodule

// ===== rtl/core/rtsc_checker.sv =====
// port checker of the range tagged second chance cache and its bind
`include "range_tagged_second_chance_cache_assert.svh"

module rtsc_checker
    import rtsc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic [0:0]            m_tuser
);

    // a stalled result holds
    `RTSC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

    // one item in work at a time
    `RTSC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "second item taken while busy")

    // no result can follow an accept in the next cycle
    `RTSC_ASSERT_NEXT(a_no_early_result, s_tvalid && s_tready, !$rose(m_tvalid), "result appeared too early")

    // padding bits of the result stay zero
    `RTSC_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_DATA_W-1:OUT_FIELDS_W] == '0, "result padding not zero")

endmodule

bind range_tagged_second_chance_cache rtsc_checker u_rtsc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
